FILE: hdl/rmvs_pkg.sv
package rmvs_pkg;

    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 8;
    localparam int XFRAC_W  = 16;
    localparam int ACC_W    = SAMPLE_W + XFRAC_W;
    localparam int DIFF_W   = ACC_W + 1;
    localparam int CNT_W    = 32;
    localparam int SQ_W     = 64;
    localparam int VAR_W    = 2 * SAMPLE_W;
    localparam int STD_W    = SAMPLE_W;
    localparam int TRIG_W   = 16;
    localparam int CFG_W    = 16;
    localparam int MDIG_W   = 16;
    localparam int MB_W     = 48;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int DIVC_W   = 7;
    localparam int SQC_W    = 5;
    localparam int SREM_W   = STD_W + 2;
    localparam int OUT_W    = CNT_W + SAMPLE_W + VAR_W + STD_W;

    localparam logic [0:0] CFG_CALC_EN = 1'b0;
    localparam logic [0:0] CFG_TRIGGER = 1'b1;

    localparam logic [TRIG_W-1:0] TRIG_RESET = 16'sd180;
    localparam logic [DIVC_W-1:0] DIV1_STEPS = 7'd41;
    localparam logic [DIVC_W-1:0] DIV2_STEPS = 7'd64;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LOAD = 9'b000000010,
        S_DIV1 = 9'b000000100,
        S_D2   = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_ACC  = 9'b000100000,
        S_DIV2 = 9'b001000000,
        S_SQRT = 9'b010000000,
        S_EMIT = 9'b100000000
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel_var;
        logic mean_upd;
        logic mul_init;
        logic mul_step;
        logic acc;
        logic var_upd;
        logic sqrt_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic act;
        logic div_done;
        logic mul_last;
        logic cnt_gt2;
        logic sqrt_last;
    } t_status;

endpackage

FILE: hdl/rmvs_div.sv
module rmvs_div
    import rmvs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    input  logic [DIVC_W-1:0] i_steps,
    output logic              o_done,
    output logic [SQ_W-1:0]   o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DIVC_W-1:0] r_cnt;
    logic [DIVC_W-1:0] r_last;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [SQ_W-1:0]   r_dq;
    logic [CNT_W:0]    n_sh;
    logic [CNT_W:0]    n_diff;
    logic              n_qbit;

    always_comb begin
        n_sh   = {r_rem, r_dq[SQ_W-1]};
        n_diff = n_sh - {1'b0, r_div};
        n_qbit = (n_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == r_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_dq   <= i_dividend;
            r_last <= i_steps - 1'b1;
        end else if (r_busy) begin
            r_rem <= n_qbit ? n_diff[CNT_W-1:0] : n_sh[CNT_W-1:0];
            r_dq  <= {r_dq[SQ_W-2:0], n_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dq;

endmodule

FILE: hdl/rmvs_dp.sv
module rmvs_dp
    import rmvs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_active,
    output logic [OUT_W-1:0]     o_data
);

    logic                r_calc_en;
    logic [TRIG_W-1:0]   r_trig;
    logic                r_started;
    logic                r_act;
    logic [CNT_W-1:0]    r_count;
    logic [ACC_W-1:0]    r_mean_acc;
    logic [DIFF_W-1:0]   r_d1;
    logic [SQ_W-1:0]     r_sq;
    logic [VAR_W-1:0]    r_var;
    logic [DIFF_W-1:0]   r_ma;
    logic [MB_W-1:0]     r_mb;
    logic [PROD_W-1:0]   r_prod;
    logic [1:0]          r_mcnt;
    logic [VAR_W-1:0]    r_sv;
    logic [SREM_W-1:0]   r_srem;
    logic [STD_W-1:0]    r_sroot;
    logic [SQC_W-1:0]    r_scnt;
    logic                r_oact;
    logic [OUT_W-1:0]    r_odata;

    logic [SAMPLE_W:0]   n_xe;
    logic [SAMPLE_W-FRAC_W:0] n_ipart;
    logic                n_started;
    logic                n_act;
    logic [CNT_W-1:0]    n_count;
    logic [ACC_W-1:0]    n_xa;
    logic [ACC_W-1:0]    r_xa;
    logic [DIFF_W-1:0]   n_d1;
    logic [DIFF_W-1:0]   n_abs_d1;
    logic [DIFF_W-1:0]   n_d2;
    logic [DIFF_W-1:0]   n_abs_d2;
    logic [DIFF_W-1:0]   n_qs;
    logic [SQ_W:0]       n_sum;
    logic [SQ_W-1:0]     n_sq;
    logic [SQ_W-1:0]     n_div_dividend;
    logic [CNT_W-1:0]    n_div_divisor;
    logic [DIVC_W-1:0]   n_div_steps;
    logic                div_done;
    logic [SQ_W-1:0]     div_quot;
    logic [VAR_W-1:0]    n_var;
    logic [SREM_W-1:0]   n_srem2;
    logic [SREM_W-1:0]   n_trial;
    logic                n_sbit;
    logic [ACC_W-1:0]    n_mean_rnd;
    logic [PROD_W-1:0]   n_part;

    always_comb begin
        n_xe      = {i_sample[SAMPLE_W-1], i_sample} +
                    (i_sample[SAMPLE_W-1] ? (SAMPLE_W+1)'((1 << FRAC_W) - 1) : '0);
        n_ipart   = n_xe[SAMPLE_W:FRAC_W];
        n_started = r_started ||
                    (n_ipart == {{(SAMPLE_W-FRAC_W+1-TRIG_W){r_trig[TRIG_W-1]}}, r_trig});
        n_act     = r_calc_en && n_started;
        n_count   = (r_count == '1) ? r_count : r_count + 1'b1;
        n_xa      = {i_sample, {XFRAC_W{1'b0}}};
        n_d1      = {n_xa[ACC_W-1], n_xa} - {r_mean_acc[ACC_W-1], r_mean_acc};
        n_abs_d1  = r_d1[DIFF_W-1] ? (~r_d1 + 1'b1) : r_d1;
        n_qs      = r_d1[DIFF_W-1] ? (~div_quot[DIFF_W-1:0] + 1'b1) : div_quot[DIFF_W-1:0];
        n_d2      = {r_xa[ACC_W-1], r_xa} - {r_mean_acc[ACC_W-1], r_mean_acc};
        n_abs_d2  = n_d2[DIFF_W-1] ? (~n_d2 + 1'b1) : n_d2;
        n_part    = PROD_W'({{MDIG_W{1'b0}}, r_ma} *
                            {{DIFF_W{1'b0}}, r_mb[MB_W-1 -: MDIG_W]});
        n_sum     = {1'b0, r_sq} + (SQ_W+1)'(r_prod[PROD_W-1:2*XFRAC_W]);
        n_sq      = n_sum[SQ_W] ? '1 : n_sum[SQ_W-1:0];
        n_var     = (div_quot[SQ_W-1:VAR_W] != '0) ? '1 : div_quot[VAR_W-1:0];
        n_srem2   = {r_srem[SREM_W-3:0], r_sv[VAR_W-1 -: 2]};
        n_trial   = {r_sroot, 2'b01};
        n_sbit    = (n_srem2 >= n_trial);
        n_mean_rnd = r_mean_acc +
                     (r_mean_acc[ACC_W-1] ? ACC_W'((1 << XFRAC_W) - 1) : '0);
        if (i_cmd.div_sel_var) begin
            n_div_dividend = n_sq;
            n_div_divisor  = r_count - 1'b1;
            n_div_steps    = DIV2_STEPS;
        end else begin
            n_div_dividend = {n_abs_d1, {(SQ_W-DIFF_W){1'b0}}};
            n_div_divisor  = r_count;
            n_div_steps    = DIV1_STEPS;
        end
    end

    rmvs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_div_dividend),
        .i_divisor  (n_div_divisor),
        .i_steps    (n_div_steps),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calc_en  <= 1'b1;
            r_trig     <= TRIG_RESET;
            r_started  <= 1'b0;
            r_act      <= 1'b0;
            r_count    <= '0;
            r_mean_acc <= '0;
            r_sq       <= '0;
            r_var      <= '0;
            r_sroot    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_CALC_EN: r_calc_en <= i_cfg_data[0];
                    CFG_TRIGGER: r_trig    <= i_cfg_data[TRIG_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_started <= n_started;
                r_act     <= n_act;
                if (n_act) begin
                    r_count <= n_count;
                end
            end
            if (i_cmd.mean_upd) begin
                r_mean_acc <= r_mean_acc + n_qs[ACC_W-1:0];
            end
            if (i_cmd.acc) begin
                r_sq <= n_sq;
            end
            if (i_cmd.var_upd) begin
                r_var   <= n_var;
                r_sroot <= '0;
            end else if (i_cmd.sqrt_step) begin
                r_sroot <= {r_sroot[STD_W-2:0], n_sbit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xa <= n_xa;
            r_d1 <= n_d1;
        end
        if (i_cmd.mul_init) begin
            r_ma   <= n_abs_d1;
            r_mb   <= MB_W'(n_abs_d2);
            r_prod <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.mul_step) begin
            r_prod <= {r_prod[PROD_W-MDIG_W-1:0], {MDIG_W{1'b0}}} + n_part;
            r_mb   <= {r_mb[MB_W-MDIG_W-1:0], {MDIG_W{1'b0}}};
            r_mcnt <= r_mcnt + 1'b1;
        end
        if (i_cmd.var_upd) begin
            r_sv   <= n_var;
            r_srem <= '0;
            r_scnt <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sv   <= {r_sv[VAR_W-3:0], 2'b00};
            r_srem <= n_sbit ? (n_srem2 - n_trial) : n_srem2;
            r_scnt <= r_scnt + 1'b1;
        end
        if (i_cmd.emit) begin
            r_oact  <= r_act;
            r_odata <= {r_sroot, r_var, n_mean_rnd[ACC_W-1:XFRAC_W], r_count};
        end
    end

    always_comb begin
        o_status.act       = r_act;
        o_status.div_done  = div_done;
        o_status.mul_last  = (r_mcnt == 2'd2);
        o_status.cnt_gt2   = (r_count > CNT_W'(2));
        o_status.sqrt_last = (r_scnt == SQC_W'(STD_W - 1));
    end

    assign o_active = r_oact;
    assign o_data   = r_odata;

endmodule

FILE: hdl/rmvs_ctrl.sv
module rmvs_ctrl
    import rmvs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_ovalid;
    logic   n_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_status.act) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DIV1: begin
                if (i_status.div_done) begin
                    o_cmd.mean_upd = 1'b1;
                    n_state        = S_D2;
                end
            end
            S_D2: begin
                o_cmd.mul_init = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_status.cnt_gt2) begin
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel_var = 1'b1;
                    n_state           = S_DIV2;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DIV2: begin
                if (i_status.div_done) begin
                    o_cmd.var_upd = 1'b1;
                    n_state       = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ovalid = o_cmd.emit ? 1'b1 : (i_out_ready ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

FILE: hdl/running_mean_variance_stats.sv
// Channel  | Direction | Handshake                    | Payload
// input    | in        | s_axis_tvalid/s_axis_tready  | tdata: sample[23:0]
// output   | out       | m_axis_tvalid/m_axis_tready  | tdata: count, mean, variance, std_dev
//          |           |                              | tuser: active
// config   | in        | cfg_valid/cfg_ready          | cfg_addr index, cfg_data value
//
// An inactive request skips the arithmetic; an accumulated one uses the shared
// shift-subtract divider (41 and 64 steps, the second once the count exceeds
// two) and the 24-step square root. Reset is synchronous and clears all
// statistics. A stalled output holds its result while the next request is taken.
module running_mean_variance_stats
    import rmvs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,   // sample
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,   // sample_count, mean, variance, std_dev
    output logic                m_axis_tuser,   // active
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_addr,
    input  logic [CFG_W-1:0]    cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign cfg_ready = 1'b1;

    rmvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rmvs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_sample   (s_axis_tdata),
        .i_cfg_we   (cfg_valid),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data),
        .o_active   (m_axis_tuser),
        .o_data     (m_axis_tdata)
    );

endmodule
